### design/fdh_pkg.sv
`default_nettype none

package fdh_pkg;

    // Payload and register widths
    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 25;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 2;

    // Defaults of the top-level parameters
    localparam int STORE_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF   = 8;

    // Entries of the queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Interpolator accumulator width; holds every Horner partial sum
    localparam int COEF_W = 32;

    localparam logic signed [COEF_W-1:0] OUT_MAX = COEF_W'(8388607);
    localparam logic signed [COEF_W-1:0] OUT_MIN = -COEF_W'(8388608);

    // Byte address of the delay register
    localparam logic [PADDR_W-1:0] REG_ADDR_DELAY = PADDR_W'(0);

endpackage

`default_nettype wire

### design/fdh_queue.sv
`default_nettype none

module fdh_queue
    import fdh_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/fdh_front.sv
`default_nettype none

module fdh_front
    import fdh_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int AW          = $clog2(STORE_DEPTH),
    parameter int ITEM_W      = SAMPLE_W + 2 * AW + FRAC_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SAMPLE_W-1:0] sample_in,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                clearing,
    input  wire logic [DELAY_W-1:0]  delay_q8,
    output logic                     push,
    output logic      [ITEM_W-1:0]   push_data,
    input  wire logic                q_full
);

    // Read position width: (write index + depth) with fraction bits
    localparam int PW = AW + 1 + FRAC_BITS;
    localparam int XW = (PW > DELAY_W) ? PW : DELAY_W;

    logic [AW-1:0]        wr_idx_reg, wr_idx_next;
    logic                 item_vld_reg, item_vld_next;
    logic [ITEM_W-1:0]    item_reg;
    logic                 accept;
    logic [AW:0]          wi_plus_n;
    logic [XW-1:0]        pos_x;
    logic [PW-1:0]        pos;
    logic [AW:0]          ip;
    logic [AW-1:0]        base;
    logic [FRAC_BITS-1:0] frac;

    assign in_stall  = clearing || (item_vld_reg && q_full);
    assign accept    = in_valid && !in_stall;
    assign push      = item_vld_reg;
    assign push_data = item_reg;

    // Read position = (write index + depth) * 2^F - delay; never negative
    always_comb
    begin
        wi_plus_n = (AW + 1)'(wr_idx_reg) + (AW + 1)'(STORE_DEPTH);
        pos_x     = (XW'(wi_plus_n) << FRAC_BITS) - XW'(delay_q8);
        pos       = pos_x[PW-1:0];
        ip        = pos[PW-1:FRAC_BITS];
        frac      = pos[FRAC_BITS-1:0];
        if (ip >= (AW + 1)'(STORE_DEPTH))
        begin
            base = AW'(ip - (AW + 1)'(STORE_DEPTH));
        end
        else
        begin
            base = ip[AW-1:0];
        end
    end

    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        item_vld_next = item_vld_reg;
        if (accept)
        begin
            wr_idx_next   = (wr_idx_reg == AW'(STORE_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
            item_vld_next = 1'b1;
        end
        else if (item_vld_reg && !q_full)
        begin
            item_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            item_vld_reg <= 1'b0;
        end
        else
        begin
            wr_idx_reg   <= wr_idx_next;
            item_vld_reg <= item_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= {sample_in, wr_idx_reg, base, frac};
        end
    end

endmodule

`default_nettype wire

### design/fdh_back.sv
`default_nettype none

module fdh_back
    import fdh_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int AW          = $clog2(STORE_DEPTH),
    parameter int ITEM_W      = SAMPLE_W + 2 * AW + FRAC_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [ITEM_W-1:0]   pop_data,
    input  wire logic                q_empty,
    output logic                     pop,
    output logic                     clearing,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [SAMPLE_W-1:0] sample_out
);

    localparam int IW = AW + 2;
    localparam int PRW = COEF_W + FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_READ,
        S_COEF,
        S_MUL,
        S_ADD,
        S_ROUND,
        S_OUT
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        clr_idx_reg;
    logic [2:0]           tap_cnt_reg;
    logic [1:0]           h_cnt_reg;
    logic                 out_valid_reg;

    logic [SAMPLE_W-1:0]  mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0]  rd_data_reg;

    logic [SAMPLE_W-1:0]  sample_reg;
    logic [AW-1:0]        widx_reg;
    logic [AW-1:0]        base_reg;
    logic [FRAC_BITS-1:0] frac_reg;

    logic signed [SAMPLE_W-1:0] y0_reg, y1_reg, y2_reg, y3_reg;
    logic signed [COEF_W-1:0]   c0_reg, c1_reg, c2_reg;
    logic signed [COEF_W-1:0]   t_reg;
    logic signed [PRW-1:0]      prod_reg;
    logic [SAMPLE_W-1:0]        sample_out_reg;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [SAMPLE_W-1:0]  mem_wdata;
    logic [IW-1:0]        tap_sum;
    logic [AW-1:0]        rd_addr;

    logic signed [COEF_W-1:0] y0x, y1x, y2x, y3x;
    logic signed [COEF_W-1:0] c1_w, c3_w, c2_w, d01, d12;
    logic signed [COEF_W-1:0] h_coef;
    logic signed [COEF_W-1:0] rnd;
    logic signed [FRAC_BITS:0] f_s;

    assign pop        = (state_reg == S_IDLE) && !q_empty;
    assign clearing   = (state_reg == S_CLEAR);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // Store write: clearing pass or the incoming sample
    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_idx_reg : widx_reg;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : sample_reg;

    // Tap address = (base + tap - 2) mod depth, taps issued in order y0..y3
    always_comb
    begin
        tap_sum = IW'(base_reg) + IW'(tap_cnt_reg[1:0]) + IW'(STORE_DEPTH) - IW'(2);
        if (tap_sum >= IW'(2 * STORE_DEPTH))
        begin
            rd_addr = AW'(tap_sum - IW'(2 * STORE_DEPTH));
        end
        else if (tap_sum >= IW'(STORE_DEPTH))
        begin
            rd_addr = AW'(tap_sum - IW'(STORE_DEPTH));
        end
        else
        begin
            rd_addr = tap_sum[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Hermite coefficients, all doubled
    always_comb
    begin
        y0x  = {{(COEF_W - SAMPLE_W){y0_reg[SAMPLE_W-1]}}, y0_reg};
        y1x  = {{(COEF_W - SAMPLE_W){y1_reg[SAMPLE_W-1]}}, y1_reg};
        y2x  = {{(COEF_W - SAMPLE_W){y2_reg[SAMPLE_W-1]}}, y2_reg};
        y3x  = {{(COEF_W - SAMPLE_W){y3_reg[SAMPLE_W-1]}}, y3_reg};
        d12  = y1x - y2x;
        d01  = y0x - y1x;
        c1_w = y2x - y0x;
        c3_w = d12 + d12 + d12 + (y3x - y0x);
        c2_w = d01 + d01 + c1_w - c3_w;
    end

    always_comb
    begin
        unique case (h_cnt_reg)
            2'd0:    h_coef = c2_reg;
            2'd1:    h_coef = c1_reg;
            default: h_coef = c0_reg;
        endcase
    end

    assign f_s = $signed({1'b0, frac_reg});
    assign rnd = (t_reg + COEF_W'(1)) >>> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            tap_cnt_reg   <= '0;
            h_cnt_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == AW'(STORE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    tap_cnt_reg <= '0;
                    state_reg   <= S_READ;
                end
                S_READ:
                begin
                    tap_cnt_reg <= tap_cnt_reg + 1'b1;
                    if (tap_cnt_reg == 3'd4)
                    begin
                        state_reg <= S_COEF;
                    end
                end
                S_COEF:
                begin
                    h_cnt_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (h_cnt_reg == 2'd2)
                    begin
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        h_cnt_reg <= h_cnt_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_ROUND:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sample_reg <= pop_data[ITEM_W-1 -: SAMPLE_W];
            widx_reg   <= pop_data[2 * AW + FRAC_BITS - 1 -: AW];
            base_reg   <= pop_data[AW + FRAC_BITS - 1 -: AW];
            frac_reg   <= pop_data[FRAC_BITS-1:0];
        end
        // Shift taps in as read data returns
        if ((state_reg == S_READ) && (tap_cnt_reg != 3'd0))
        begin
            y0_reg <= y1_reg;
            y1_reg <= y2_reg;
            y2_reg <= y3_reg;
            y3_reg <= $signed(rd_data_reg);
        end
        if (state_reg == S_COEF)
        begin
            c0_reg <= y1x + y1x;
            c1_reg <= c1_w;
            c2_reg <= c2_w;
            t_reg  <= c3_w;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PRW'(t_reg) * PRW'(f_s);
        end
        // Arithmetic shift of the product is a floor division by 2^F
        if (state_reg == S_ADD)
        begin
            t_reg <= $signed(prod_reg[FRAC_BITS +: COEF_W]) + h_coef;
        end
        if (state_reg == S_ROUND)
        begin
            priority if (rnd > OUT_MAX)
            begin
                sample_out_reg <= OUT_MAX[SAMPLE_W-1:0];
            end
            else if (rnd < OUT_MIN)
            begin
                sample_out_reg <= OUT_MIN[SAMPLE_W-1:0];
            end
            else
            begin
                sample_out_reg <= rnd[SAMPLE_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

### design/fractional_delay_hermite_core.sv
`default_nettype none

// Fractional delay line with 4-point cubic Hermite interpolation. Each input
// transaction writes one 24-bit sample into a circular store of STORE_DEPTH
// entries and yields one output transaction: the store read at the current
// position minus delay_q8 (samples with FRAC_BITS fraction bits), with taps at
// -2, -1, 0 and +1 around that position, so the delay seen at the output is
// one sample longer than the register value. Writes of delay_q8 above
// STORE_DEPTH samples saturate to that limit. After reset the store is
// cleared one entry per cycle, all STORE_DEPTH entries (65536 by default),
// and in_stall stays high for that time; register writes are taken throughout.
// The back end takes one sample at a time through an idle state that pops the
// queue, one store write and four tap reads whose read data is registered, a
// coefficient state, three multiply/add pairs of the Horner evaluation, a
// rounding state and an output state held while out_stall is high. A two-entry
// queue in front lets the source hand over further samples while a result waits
// on out_stall.

module fractional_delay_hermite_core
    import fdh_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic [SAMPLE_W-1:0]   sample_in,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic      [SAMPLE_W-1:0]   sample_out,
    output logic                       out_valid,
    input  wire logic                  out_stall
);

    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int ITEM_W = SAMPLE_W + 2 * AW + FRAC_BITS;
    localparam int LW     = AW + FRAC_BITS + 1;
    localparam int CW     = (LW > DELAY_W) ? LW : DELAY_W;
    localparam logic [CW-1:0] DELAY_LIMIT = CW'(STORE_DEPTH) << FRAC_BITS;

    logic [DELAY_W-1:0] delay_q8_reg;
    logic               cfg_write;
    logic [CW-1:0]      wdata_x;
    logic               push;
    logic [ITEM_W-1:0]  push_data;
    logic [ITEM_W-1:0]  pop_data;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic               clearing;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign wdata_x   = CW'(pwdata[DELAY_W-1:0]);
    assign prdata    = (paddr == REG_ADDR_DELAY) ? CFG_DATA_W'(delay_q8_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_q8_reg <= '0;
        end
        else if (cfg_write)
        begin
            // Saturate to the full store depth
            if (wdata_x > DELAY_LIMIT)
            begin
                delay_q8_reg <= DELAY_LIMIT[DELAY_W-1:0];
            end
            else
            begin
                delay_q8_reg <= pwdata[DELAY_W-1:0];
            end
        end
    end

    fdh_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAC_BITS   (FRAC_BITS),
        .AW          (AW),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .clearing  (clearing),
        .delay_q8  (delay_q8_reg),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    fdh_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    fdh_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAC_BITS   (FRAC_BITS),
        .AW          (AW),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .q_empty    (q_empty),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fdh_pkg::*;

    localparam int DEPTH          = STORE_DEPTH_DEF;
    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 85;
    // covers the store clearing pass after reset with room to spare
    localparam int WATCHDOG_LIMIT = 4 * DEPTH;

    localparam logic [DELAY_W-1:0]  DELAY_LIMIT = DELAY_W'(DEPTH) << FRAC;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint OUT_HI = 2 ** (SAMPLE_W - 1) - 1;
    localparam longint OUT_LO = -(2 ** (SAMPLE_W - 1));

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [PADDR_W-1:0]    paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic [SAMPLE_W-1:0]   sample_in = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample_out;
    logic                  out_valid;
    logic                  out_stall = 1'b0;

    // Mirror of the block state
    logic signed [SAMPLE_W-1:0] delay_line [DEPTH];
    logic [IDX_W-1:0]           wr_ptr;
    logic [DELAY_W-1:0]         delay_setting;
    logic [SAMPLE_W-1:0]        pending_out [$];

    int mismatches;
    int n_sent;
    int n_checked;
    int n_saturated;
    int n_settings;
    int burst_left;
    int idle_count;

    // Receiver state
    rx_mode_t            rx_mode = RX_FREE;
    int                  rx_mode_left;
    int                  rx_cycle;
    int                  hold_len;
    int                  hold_left;
    bit                  hold_toggle;
    bit                  hold_seen;
    logic [SAMPLE_W-1:0] rx_want;

    fractional_delay_hermite_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (sample_in),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_out (sample_out),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

    always #1 clk = ~clk;

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Cubic Hermite on doubled coefficients, floor after every scaling step
    function automatic logic [SAMPLE_W-1:0] hermite_interp(
        input logic signed [SAMPLE_W-1:0] y0,
        input logic signed [SAMPLE_W-1:0] y1,
        input logic signed [SAMPLE_W-1:0] y2,
        input logic signed [SAMPLE_W-1:0] y3,
        input logic [FRAC-1:0]            frac
    );
        longint c0, c1, c2, c3, f, acc;
        c0 = 2 * longint'(y1);
        c1 = longint'(y2) - longint'(y0);
        c3 = 3 * (longint'(y1) - longint'(y2)) + (longint'(y3) - longint'(y0));
        c2 = 2 * longint'(y0) - 2 * longint'(y1) + c1 - c3;
        f = longint'(frac);
        acc = c3;
        acc = ((acc * f) >>> FRAC) + c2;
        acc = ((acc * f) >>> FRAC) + c1;
        acc = ((acc * f) >>> FRAC) + c0;
        acc = (acc + 1) >>> 1;
        if (acc > OUT_HI)
        begin
            acc = OUT_HI;
            n_saturated++;
        end
        else if (acc < OUT_LO)
        begin
            acc = OUT_LO;
            n_saturated++;
        end
        return SAMPLE_W'(acc);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($urandom_range(0, 64) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one sample, hold it until taken, then predict its output
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        logic [63:0]      pos;
        logic [IDX_W-1:0] ip;
        sample_in <= s;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall);
        delay_line[wr_ptr] = s;
        pos = ((64'(wr_ptr) + 64'(DEPTH)) << FRAC) - 64'(delay_setting);
        ip  = pos[FRAC +: IDX_W];
        pending_out.push_back(hermite_interp(delay_line[IDX_W'(ip - 2)],
                                             delay_line[IDX_W'(ip - 1)],
                                             delay_line[ip],
                                             delay_line[IDX_W'(ip + 1)],
                                             pos[FRAC-1:0]));
        wr_ptr = wr_ptr + 1'b1;
        n_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_out.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_stream(input int count);
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            send_sample(rand_sample());
            burst_left--;
        end
    endtask

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write the delay, mirror the mask and clamp, read it back
    task automatic set_delay(input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] readback;
        logic [DELAY_W-1:0]    masked;
        apb_access(1'b1, REG_ADDR_DELAY, value, readback);
        masked = value[DELAY_W-1:0];
        delay_setting = (masked > DELAY_LIMIT) ? DELAY_LIMIT : masked;
        apb_access(1'b0, REG_ADDR_DELAY, '0, readback);
        if (readback !== CFG_DATA_W'(delay_setting))
            note_mismatch("delay_q8 readback", CFG_DATA_W'(delay_setting), readback);
        n_settings++;
    endtask

    // Reset value of the register, then delay zero: each output is the previous input
    task automatic test_reset_state();
        logic [CFG_DATA_W-1:0] readback;
        apb_access(1'b0, REG_ADDR_DELAY, '0, readback);
        if (readback !== '0)
            note_mismatch("delay_q8 after reset", '0, readback);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('1);
        send_sample(SAMPLE_W'(1));
        drain_outputs();
    endtask

    // Half-sample delay over full-scale steps overshoots both rails
    task automatic test_extreme_samples();
        set_delay(32'h0000_0080);
        repeat (2)
        begin
            send_sample(SAMPLE_MIN);
            send_sample(SAMPLE_MAX);
            send_sample(SAMPLE_MAX);
            send_sample(SAMPLE_MIN);
        end
        drain_outputs();
    endtask

    // Full depth, writes above the limit, and junk above the register width
    task automatic test_delay_register();
        logic [CFG_DATA_W-1:0] values [4];
        values = '{CFG_DATA_W'(DELAY_LIMIT), 32'h01FF_FFFF, 32'hFFFF_FFFF, 32'hFE00_0100};
        foreach (values[i])
        begin
            set_delay(values[i]);
            repeat (2) send_sample(rand_sample());
            drain_outputs();
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] value;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: value = $urandom_range(0, 8 << FRAC);
                1: value = $urandom_range(0, (1 << FRAC) - 1);
                2: value = $urandom_range(0, 16) << FRAC;
                3: value = CFG_DATA_W'(DELAY_LIMIT) - $urandom_range(0, 4 << FRAC);
                4: value = $urandom;
                default: value = $urandom_range(0, 3 << FRAC)
                                 | (CFG_DATA_W'($urandom_range(1, 127)) << DELAY_W);
            endcase
            set_delay(value);
            send_stream(PHASE_ITEMS);
            drain_outputs();
        end
    endtask

    // Hold the output long enough to fill the block, then pause for a full drain
    task automatic test_backpressure();
        set_delay((3 << FRAC) + 64);
        hold_len    = 300;
        hold_toggle = ~hold_toggle;
        repeat (24) send_sample(rand_sample());
        drain_outputs();
        repeat (12) send_sample(rand_sample());
        drain_outputs();
    endtask

    // Check each output transaction, then pick the next stall value
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
                note_mismatch("sample_out with nothing pending", '0, 32'(sample_out));
            else
            begin
                rx_want = pending_out.pop_front();
                if (sample_out !== rx_want)
                    note_mismatch("sample_out", 32'(rx_want), 32'(sample_out));
                n_checked++;
            end
        end
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = hold_len;
        end
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 160);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= ((rx_cycle % 7) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable && pready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        foreach (delay_line[i])
            delay_line[i] = '0;
        wr_ptr        = '0;
        delay_setting = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_extreme_samples();
        test_delay_register();
        test_random_traffic();
        test_backpressure();

        mismatches += pending_out.size();
        $display("Run covered %0d samples in and %0d checked out over %0d delay settings,",
                 n_sent, n_checked, n_settings);
        $display("with %0d saturated outputs, a long output hold and full drains.",
                 n_saturated);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
